/* src/rzad_pkg.sv */
package rzad_pkg;

   localparam int METER_COUNT = 16;
   localparam int MAX_WINDOW = 64;
   localparam int SAMPLE_BITS = 24;

   localparam int METER_BITS = $clog2(METER_COUNT);
   localparam int SLOT_BITS = $clog2(MAX_WINDOW);
   localparam int RING_DEPTH = METER_COUNT * MAX_WINDOW;
   localparam int RING_ADDR_BITS = $clog2(RING_DEPTH);
   localparam int COUNT_BITS = 7;
   localparam int SUM_BITS = 31;
   localparam int SQSUM_BITS = 53;
   localparam int DIFF_BITS = 32;
   localparam int DEV_BITS = 60;
   localparam int A2_BITS = 62;
   localparam int LHS_BITS = 84;
   localparam int ND_BITS = 68;
   localparam int LIMB_BITS = 32;
   localparam int OPND_BITS = 96;
   localparam int ACC_BITS = 128;
   localparam int Z_BITS = 16;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_WARMUP = 2'd1;
   localparam logic [1:0] REG_WINDOW = 2'd2;

   localparam logic [15:0] THRESHOLD_RESET = 16'd768;
   localparam logic [COUNT_BITS-1:0] WARMUP_RESET = 7'd8;
   localparam logic [COUNT_BITS-1:0] WINDOW_RESET = 7'd64;

   typedef struct packed {
      logic [METER_BITS-1:0] meter;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] window_mean;
      logic signed [Z_BITS-1:0] z_score;
      logic anomaly_flag;
      logic warmup_flag;
   } rsp_type;

   typedef struct packed {
      logic [15:0] threshold;
      logic [COUNT_BITS-1:0] warmup_count;
      logic [COUNT_BITS-1:0] window_length;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_VSQ, OP_QN, OP_SSQ, OP_T2, OP_A2, OP_LHS, OP_ND, OP_NDT, OP_CSQ, OP_NDS, OP_OSQ
   } eng_op_type;

   typedef struct packed {
      logic load;
      logic diff_load;
      logic flat_set;
      logic start;
      logic finish;
      eng_op_type op;
      logic sinit;
      logic snext;
      logic zset;
      logic rd_old;
      logic n_inc;
      logic insert;
      logic store;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic eng_idle;
      logic warming;
      logic n_lt2;
      logic dev_zero;
      logic n_ge_len;
      logic bit_zero;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

/* src/rzad_ram.sv */
module rzad_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/rzad_ctrl.sv */
module rzad_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rzad_pkg::status_type   status,
   output rzad_pkg::cmd_type      cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_VSQ, ST_JUDGE, ST_QN, ST_SSQ, ST_DEVCHK, ST_FLAT, ST_T2, ST_A2, ST_LHS,
      ST_ND, ST_NDT, ST_SINIT, ST_CSQ, ST_NDS, ST_SNEXT, ST_ZSET, ST_UPDATE, ST_OLDRD,
      ST_INSERT, ST_STORE, ST_DIV, ST_OUT, ST_WAIT
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   rzad_pkg::eng_op_type op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      op_in = op_ff;
      cmd = '0;
      cmd.op = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_VSQ;
            end
         end
         ST_VSQ: begin
            op_in = rzad_pkg::OP_VSQ;
            ret_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            cmd.diff_load = 1'b1;
            if (status.warming) begin
               state_in = ST_UPDATE;
            end else if (status.n_lt2) begin
               state_in = ST_FLAT;
            end else begin
               state_in = ST_QN;
            end
         end
         ST_QN: begin
            op_in = rzad_pkg::OP_QN;
            ret_in = ST_SSQ;
         end
         ST_SSQ: begin
            op_in = rzad_pkg::OP_SSQ;
            ret_in = ST_DEVCHK;
         end
         ST_DEVCHK: begin
            state_in = status.dev_zero ? ST_FLAT : ST_T2;
         end
         ST_FLAT: begin
            cmd.flat_set = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_T2: begin
            op_in = rzad_pkg::OP_T2;
            ret_in = ST_A2;
         end
         ST_A2: begin
            op_in = rzad_pkg::OP_A2;
            ret_in = ST_LHS;
         end
         ST_LHS: begin
            op_in = rzad_pkg::OP_LHS;
            ret_in = ST_ND;
         end
         ST_ND: begin
            op_in = rzad_pkg::OP_ND;
            ret_in = ST_NDT;
         end
         ST_NDT: begin
            op_in = rzad_pkg::OP_NDT;
            ret_in = ST_SINIT;
         end
         ST_SINIT: begin
            cmd.sinit = 1'b1;
            state_in = ST_CSQ;
         end
         ST_CSQ: begin
            op_in = rzad_pkg::OP_CSQ;
            ret_in = ST_NDS;
         end
         ST_NDS: begin
            op_in = rzad_pkg::OP_NDS;
            ret_in = ST_SNEXT;
         end
         ST_SNEXT: begin
            if (status.bit_zero) begin
               state_in = ST_ZSET;
            end else begin
               cmd.snext = 1'b1;
               state_in = ST_CSQ;
            end
         end
         ST_ZSET: begin
            cmd.zset = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.n_ge_len) begin
               cmd.rd_old = 1'b1;
               state_in = ST_OLDRD;
            end else begin
               cmd.n_inc = 1'b1;
               state_in = ST_INSERT;
            end
         end
         ST_OLDRD: begin
            op_in = rzad_pkg::OP_OSQ;
            ret_in = ST_INSERT;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WAIT: begin
            if (status.eng_idle) begin
               cmd.finish = 1'b1;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      case (state_ff)
         ST_VSQ, ST_QN, ST_SSQ, ST_T2, ST_A2, ST_LHS, ST_ND, ST_NDT, ST_CSQ, ST_NDS,
         ST_OLDRD: begin
            cmd.start = 1'b1;
            cmd.op = op_in;
            state_in = ST_WAIT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         op_ff <= rzad_pkg::OP_VSQ;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         op_ff <= op_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> status.eng_idle) else $error("engine started while busy");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free) else $error("result loaded over a pending one");
   a_load_leaves: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> req_stall) else $error("request taken without leaving idle");

endmodule

/* src/rzad_dpath.sv */
module rzad_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  rzad_pkg::cfg_type     cfg,
   input  rzad_pkg::req_type     req_data,
   input  logic                  rsp_stall,
   input  rzad_pkg::cmd_type     cmd,
   output rzad_pkg::status_type  status,
   output rzad_pkg::rsp_type     rsp_data,
   output logic                  rsp_valid
);

   localparam int MB = rzad_pkg::METER_BITS;
   localparam int SB = rzad_pkg::SLOT_BITS;
   localparam int VB = rzad_pkg::SAMPLE_BITS;
   localparam int NB = rzad_pkg::COUNT_BITS;
   localparam int SUMB = rzad_pkg::SUM_BITS;
   localparam int QB = rzad_pkg::SQSUM_BITS;
   localparam int LB = rzad_pkg::LIMB_BITS;
   localparam int AB = rzad_pkg::ACC_BITS;
   localparam int OB = rzad_pkg::OPND_BITS;

   logic signed [SUMB-1:0] sum_mem_ff [rzad_pkg::METER_COUNT];
   logic [QB-1:0] sq_mem_ff [rzad_pkg::METER_COUNT];
   logic [NB-1:0] fill_mem_ff [rzad_pkg::METER_COUNT];
   logic [SB-1:0] old_mem_ff [rzad_pkg::METER_COUNT];

   logic [MB-1:0] m_ff;
   logic signed [VB-1:0] v_ff, old_ff;
   logic [NB-1:0] n_ff;
   logic signed [SUMB-1:0] s_ff;
   logic [QB-1:0] q_ff;
   logic [SB-1:0] oldest_ff, pos_ff;
   logic warm_ff, anom_ff;
   logic [2*VB-1:0] vsq_ff;
   logic signed [rzad_pkg::DIFF_BITS-1:0] diff_ff;
   logic [rzad_pkg::DEV_BITS-1:0] dev_ff;
   logic [rzad_pkg::A2_BITS-1:0] a2_ff;
   logic [rzad_pkg::LHS_BITS-1:0] lhs_ff;
   logic [rzad_pkg::ND_BITS-1:0] nd_ff;
   logic [LB-1:0] t2_ff, sq_ff;
   logic [15:0] r_ff;
   logic [3:0] bit_ff;
   logic signed [rzad_pkg::Z_BITS-1:0] z_ff;

   logic [OB-1:0] eng_a_ff;
   logic [LB-1:0] eng_b_ff;
   logic [1:0] eng_last_ff, eng_k_ff, eng_kd_ff;
   logic eng_busy_ff, eng_pv_ff, eng_sub_ff;
   logic [2*LB-1:0] prod_ff;
   logic [AB-1:0] acc_ff;

   logic [SUMB-1:0] div_ff;
   logic [NB-1:0] rem_ff, div_n_ff;
   logic [4:0] div_cnt_ff;
   logic div_busy_ff, div_neg_ff;

   logic rsp_valid_ff;
   rzad_pkg::rsp_type rsp_data_ff;

   logic [VB-1:0] v_mag, old_mag, ram_rd_data;
   logic [SUMB-1:0] s_mag;
   logic [rzad_pkg::DIFF_BITS-1:0] diff_mag;
   logic [NB-1:0] len_c;
   logic [15:0] cand;
   logic signed [rzad_pkg::DIFF_BITS-1:0] vn;
   logic [OB-1:0] op_a;
   logic [LB-1:0] op_b;
   logic [1:0] op_last;
   logic op_clear, op_sub;
   logic [LB-1:0] eng_limb;
   logic [AB-1:0] prod_sh;
   logic [NB:0] div_trial;
   logic [SUMB-1:0] mean_full;
   logic [AB-1:0] lhs_wide;

   rzad_ram #(
      .WIDTH(VB),
      .DEPTH(rzad_pkg::RING_DEPTH)
   ) u_ring (
      .clock(clock),
      .wr_en(cmd.insert),
      .wr_addr({m_ff, pos_ff}),
      .wr_data(v_ff),
      .rd_en(cmd.rd_old),
      .rd_addr({m_ff, oldest_ff}),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      v_mag = v_ff[VB-1] ? VB'(-v_ff) : VB'(v_ff);
      old_mag = ram_rd_data[VB-1] ? VB'(-$signed(ram_rd_data)) : ram_rd_data;
      s_mag = s_ff[SUMB-1] ? SUMB'(-s_ff) : SUMB'(s_ff);
      diff_mag = diff_ff[rzad_pkg::DIFF_BITS-1] ? rzad_pkg::DIFF_BITS'(-diff_ff) :
                 rzad_pkg::DIFF_BITS'(diff_ff);
      if (cfg.window_length == '0) begin
         len_c = NB'(1);
      end else if (cfg.window_length > NB'(rzad_pkg::MAX_WINDOW)) begin
         len_c = NB'(rzad_pkg::MAX_WINDOW);
      end else begin
         len_c = cfg.window_length;
      end
      cand = r_ff | (16'd1 << bit_ff);
      vn = rzad_pkg::DIFF_BITS'(v_ff) *
           rzad_pkg::DIFF_BITS'($signed({1'b0, n_ff}));
      lhs_wide = AB'(lhs_ff);
      div_trial = {rem_ff, div_ff[SUMB-1]};
      mean_full = div_neg_ff ? SUMB'(-div_ff) : div_ff;
   end

   always_comb begin
      op_a = '0;
      op_b = '0;
      op_last = 2'd0;
      op_clear = 1'b1;
      op_sub = 1'b0;
      case (cmd.op)
         rzad_pkg::OP_VSQ: begin
            op_a = OB'(v_mag);
            op_b = LB'(v_mag);
         end
         rzad_pkg::OP_QN: begin
            op_a = OB'(q_ff);
            op_b = LB'(n_ff);
            op_last = 2'd1;
         end
         rzad_pkg::OP_SSQ: begin
            op_a = OB'(s_mag);
            op_b = LB'(s_mag);
            op_clear = 1'b0;
            op_sub = 1'b1;
         end
         rzad_pkg::OP_T2: begin
            op_a = OB'(cfg.threshold);
            op_b = LB'(cfg.threshold);
         end
         rzad_pkg::OP_A2: begin
            op_a = OB'(diff_mag);
            op_b = diff_mag;
         end
         rzad_pkg::OP_LHS: begin
            op_a = OB'(a2_ff);
            op_b = LB'(n_ff - NB'(1));
            op_last = 2'd1;
         end
         rzad_pkg::OP_ND: begin
            op_a = OB'(dev_ff);
            op_b = LB'(n_ff);
            op_last = 2'd1;
         end
         rzad_pkg::OP_NDT: begin
            op_a = OB'(nd_ff);
            op_b = t2_ff;
            op_last = 2'd2;
         end
         rzad_pkg::OP_CSQ: begin
            op_a = OB'(cand);
            op_b = LB'(cand);
         end
         rzad_pkg::OP_NDS: begin
            op_a = OB'(nd_ff);
            op_b = sq_ff;
            op_last = 2'd2;
         end
         rzad_pkg::OP_OSQ: begin
            op_a = OB'(old_mag);
            op_b = LB'(old_mag);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      case (eng_k_ff)
         2'd0: eng_limb = eng_a_ff[LB-1:0];
         2'd1: eng_limb = eng_a_ff[2*LB-1:LB];
         2'd2: eng_limb = eng_a_ff[3*LB-1:2*LB];
         default: eng_limb = '0;
      endcase
      case (eng_kd_ff)
         2'd0: prod_sh = AB'(prod_ff);
         2'd1: prod_sh = AB'({prod_ff, {LB{1'b0}}});
         2'd2: prod_sh = AB'({prod_ff, {2*LB{1'b0}}});
         default: prod_sh = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rzad_pkg::METER_COUNT; i++) begin
            sum_mem_ff[i] <= '0;
            sq_mem_ff[i] <= '0;
            fill_mem_ff[i] <= '0;
            old_mem_ff[i] <= '0;
         end
         eng_busy_ff <= 1'b0;
         eng_pv_ff <= 1'b0;
         div_busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.store) begin
            sum_mem_ff[m_ff] <= s_ff;
            sq_mem_ff[m_ff] <= q_ff;
            fill_mem_ff[m_ff] <= n_ff;
            old_mem_ff[m_ff] <= oldest_ff;
         end
         if (cmd.start) begin
            eng_busy_ff <= 1'b1;
         end else if (eng_busy_ff && eng_k_ff == eng_last_ff) begin
            eng_busy_ff <= 1'b0;
         end
         eng_pv_ff <= eng_busy_ff;
         if (cmd.store) begin
            div_busy_ff <= 1'b1;
         end else if (div_busy_ff && div_cnt_ff == 5'(SUMB - 1)) begin
            div_busy_ff <= 1'b0;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         eng_a_ff <= op_a;
         eng_b_ff <= op_b;
         eng_last_ff <= op_last;
         eng_sub_ff <= op_sub;
         eng_k_ff <= 2'd0;
         if (op_clear) begin
            acc_ff <= '0;
         end
      end else begin
         if (eng_busy_ff) begin
            eng_k_ff <= eng_k_ff + 2'd1;
         end
         if (eng_pv_ff) begin
            acc_ff <= eng_sub_ff ? acc_ff - prod_sh : acc_ff + prod_sh;
         end
      end
      prod_ff <= eng_limb * eng_b_ff;
      eng_kd_ff <= eng_k_ff;

      if (cmd.load) begin
         m_ff <= req_data.meter;
         v_ff <= req_data.sample;
         n_ff <= fill_mem_ff[req_data.meter];
         s_ff <= sum_mem_ff[req_data.meter];
         q_ff <= sq_mem_ff[req_data.meter];
         oldest_ff <= old_mem_ff[req_data.meter];
         pos_ff <= old_mem_ff[req_data.meter] + SB'(fill_mem_ff[req_data.meter]);
         warm_ff <= fill_mem_ff[req_data.meter] < cfg.warmup_count;
         z_ff <= '0;
         anom_ff <= 1'b0;
      end
      if (cmd.diff_load) begin
         diff_ff <= vn - rzad_pkg::DIFF_BITS'(s_ff);
      end
      if (cmd.flat_set) begin
         anom_ff <= (n_ff == '0) ? (v_ff != '0) : (diff_ff != '0);
      end
      if (cmd.start && cmd.op == rzad_pkg::OP_OSQ) begin
         old_ff <= ram_rd_data;
      end
      if (cmd.finish) begin
         case (cmd.op)
            rzad_pkg::OP_VSQ: vsq_ff <= acc_ff[2*VB-1:0];
            rzad_pkg::OP_SSQ: dev_ff <= acc_ff[rzad_pkg::DEV_BITS-1:0];
            rzad_pkg::OP_T2: t2_ff <= acc_ff[LB-1:0];
            rzad_pkg::OP_A2: a2_ff <= acc_ff[rzad_pkg::A2_BITS-1:0];
            rzad_pkg::OP_LHS: lhs_ff <= {acc_ff[rzad_pkg::LHS_BITS-17:0], 16'd0};
            rzad_pkg::OP_ND: nd_ff <= acc_ff[rzad_pkg::ND_BITS-1:0];
            rzad_pkg::OP_NDT: anom_ff <= lhs_wide > acc_ff;
            rzad_pkg::OP_CSQ: sq_ff <= acc_ff[LB-1:0];
            rzad_pkg::OP_NDS: begin
               if (acc_ff <= lhs_wide) begin
                  r_ff <= cand;
               end
            end
            rzad_pkg::OP_OSQ: begin
               q_ff <= q_ff - acc_ff[QB-1:0];
               s_ff <= s_ff - SUMB'(old_ff);
               oldest_ff <= oldest_ff + SB'(1);
            end
            default: begin
            end
         endcase
      end
      if (cmd.sinit) begin
         r_ff <= '0;
         bit_ff <= 4'd15;
      end
      if (cmd.snext) begin
         bit_ff <= bit_ff - 4'd1;
      end
      if (cmd.zset) begin
         if (diff_ff < 0) begin
            z_ff <= r_ff[15] ? -16'sd32768 : -$signed(r_ff);
         end else begin
            z_ff <= r_ff[15] ? 16'sd32767 : $signed(r_ff);
         end
      end
      if (cmd.n_inc) begin
         n_ff <= n_ff + NB'(1);
      end
      if (cmd.insert) begin
         s_ff <= s_ff + SUMB'(v_ff);
         q_ff <= q_ff + QB'(vsq_ff);
      end

      if (cmd.store) begin
         div_ff <= s_mag;
         div_n_ff <= n_ff;
         rem_ff <= '0;
         div_cnt_ff <= '0;
         div_neg_ff <= s_ff[SUMB-1];
      end else if (div_busy_ff) begin
         if (div_trial >= {1'b0, div_n_ff}) begin
            rem_ff <= NB'(div_trial - {1'b0, div_n_ff});
            div_ff <= {div_ff[SUMB-2:0], 1'b1};
         end else begin
            rem_ff <= div_trial[NB-1:0];
            div_ff <= {div_ff[SUMB-2:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff + 5'd1;
      end

      if (cmd.out_load) begin
         rsp_data_ff.window_mean <= mean_full[VB-1:0];
         rsp_data_ff.z_score <= z_ff;
         rsp_data_ff.anomaly_flag <= anom_ff;
         rsp_data_ff.warmup_flag <= warm_ff;
      end
   end

   always_comb begin
      status.eng_idle = !eng_busy_ff && !eng_pv_ff;
      status.warming = warm_ff;
      status.n_lt2 = n_ff < NB'(2);
      status.dev_zero = (dev_ff == '0);
      status.n_ge_len = n_ff >= len_c;
      status.bit_zero = (bit_ff == '0);
      status.div_done = !div_busy_ff;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> !div_busy_ff) else $error("divider restarted while busy");
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!eng_busy_ff && !eng_pv_ff)) else $error("result taken early");
   a_store_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (n_ff != '0)) else $error("mean taken over an empty window");

endmodule

/* src/rolling_zscore_anomaly_detector_core.sv */
// Channel   Direction  Handshake                  Payload
// req       in         req_valid / req_stall      req_data (meter, sample)
// rsp       out        rsp_valid / rsp_stall      rsp_data (mean, z, anomaly, warming)
// csr       in/out     psel/penable/pwrite/pready paddr, pwdata, prdata
// One request is worked at a time on a shared 32x32 multiplier and a serial divider.
// A warming request skips the score, a flat one sets the anomaly flag directly, and a judged
// one runs a sixteen-step square-root search; evicting the oldest sample adds a ring read.
// Reset clears per-meter sums and counts at once; the sample ring is not cleared.
// req_stall is high from acceptance until the result is loaded into the output
// register, which holds while rsp_stall is high.
module rolling_zscore_anomaly_detector_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  rzad_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rzad_pkg::rsp_type                      rsp_data,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [rzad_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [rzad_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [rzad_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                   pready
);

   rzad_pkg::cfg_type cfg_ff;
   rzad_pkg::cmd_type cmd;
   rzad_pkg::status_type status;
   logic [1:0] reg_index;

   assign reg_index = paddr[3:2];
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= rzad_pkg::THRESHOLD_RESET;
         cfg_ff.warmup_count <= rzad_pkg::WARMUP_RESET;
         cfg_ff.window_length <= rzad_pkg::WINDOW_RESET;
      end else if (psel && penable && pwrite) begin
         case (reg_index)
            rzad_pkg::REG_THRESHOLD: cfg_ff.threshold <= pwdata[15:0];
            rzad_pkg::REG_WARMUP: cfg_ff.warmup_count <= pwdata[6:0];
            rzad_pkg::REG_WINDOW: cfg_ff.window_length <= pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         rzad_pkg::REG_THRESHOLD: prdata = 32'(cfg_ff.threshold);
         rzad_pkg::REG_WARMUP: prdata = 32'(cfg_ff.warmup_count);
         rzad_pkg::REG_WINDOW: prdata = 32'(cfg_ff.window_length);
         default: prdata = '0;
      endcase
   end

   rzad_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status(status),
      .cmd(cmd)
   );

   rzad_dpath u_dpath (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_data(req_data),
      .rsp_stall(rsp_stall),
      .cmd(cmd),
      .status(status),
      .rsp_data(rsp_data),
      .rsp_valid(rsp_valid)
   );

endmodule
